/* design/alx_pkg.sv */
// Shared types, constants and character classes for the assembly lexer.
// No dependencies; used by every module of the block.
package alx_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int LINE_WIDTH_DEF   = 20;
  localparam int COLUMN_WIDTH_DEF = 16;

  localparam int OFS_FW  = 32;
  localparam int LINE_FW = 20;
  localparam int COL_FW  = 16;
  localparam int TAG_FW  = 16;
  localparam int KIND_FW = 4;
  localparam int DATA_W  = 2 * OFS_FW + 2 * LINE_FW + 2 * COL_FW + TAG_FW;
  localparam int ECOL_LSB = 2 * OFS_FW + 2 * LINE_FW + COL_FW;

  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_DEC,
    MODE_ZERO,
    MODE_HEX,
    MODE_IDENT,
    MODE_ERROR
  } alx_mode_t;

  typedef enum logic [KIND_FW-1:0] {
    KIND_NEWLINE,
    KIND_COMMA,
    KIND_PLUS,
    KIND_MINUS,
    KIND_LBR,
    KIND_RBR,
    KIND_INT,
    KIND_IDENT,
    KIND_ERROR,
    KIND_DONE
  } alx_kind_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    alx_kind_t          kind;
    logic [OFS_FW-1:0]  boff;
    logic [OFS_FW-1:0]  eoff;
    logic [LINE_FW-1:0] bline;
    logic [COL_FW-1:0]  bcol;
    logic [LINE_FW-1:0] eline;
    logic [COL_FW-1:0]  ecol;
    logic [TAG_FW-1:0]  src;
    logic               last;
  } alx_res_t;

  typedef struct packed {
    logic [1:0] n;
    alx_res_t   r0;
    alx_res_t   r1;
  } alx_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_LBR) ||
           (c == CH_RBR);
  endfunction

  function automatic alx_kind_t punct_kind(input logic [7:0] c);
    alx_kind_t k;
    k = KIND_RBR;
    unique case (c)
      CH_COMMA: k = KIND_COMMA;
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_LBR:   k = KIND_LBR;
      default:  k = KIND_RBR;
    endcase
    return k;
  endfunction

endpackage

/* design/alx_core.sv */
// Lexer state: scan mode, position counters and token start, plus result formation.
// Depends on alx_pkg; pushes up to two results per item into alx_outq.
module alx_core #(
  parameter int OFFSET_WIDTH = alx_pkg::OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = alx_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = alx_pkg::COLUMN_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic                      opcode,
  input  logic [7:0]                symbol,
  input  logic [alx_pkg::TAG_FW-1:0] tag,
  output alx_pkg::alx_push_t        push
);
  import alx_pkg::*;

  alx_mode_t               mode_r,      mode_nxt;
  logic [OFFSET_WIDTH-1:0] off_r,       off_nxt;
  logic [LINE_WIDTH-1:0]   line_r,      line_nxt;
  logic [COLUMN_WIDTH-1:0] col_r,       col_nxt;
  logic [OFFSET_WIDTH-1:0] tstart_off_r, tstart_off_nxt;
  logic [COLUMN_WIDTH-1:0] tstart_col_r, tstart_col_nxt;

  logic [OFFSET_WIDTH-1:0] off_inc;
  logic [LINE_WIDTH-1:0]   line_inc;
  logic [COLUMN_WIDTH-1:0] col_inc;
  logic                    pending, extend, flush, sec_v;
  alx_res_t                tok, sec;

  function automatic alx_res_t mk_res(
    input alx_kind_t               k,
    input logic [OFFSET_WIDTH-1:0] bo,
    input logic [OFFSET_WIDTH-1:0] eo,
    input logic [LINE_WIDTH-1:0]   bl,
    input logic [COLUMN_WIDTH-1:0] bc,
    input logic [LINE_WIDTH-1:0]   el,
    input logic [COLUMN_WIDTH-1:0] ec,
    input logic [TAG_FW-1:0]       s
  );
    alx_res_t r;
    r.kind  = k;
    r.boff  = OFS_FW'(bo);
    r.eoff  = OFS_FW'(eo);
    r.bline = LINE_FW'(bl);
    r.bcol  = COL_FW'(bc);
    r.eline = LINE_FW'(el);
    r.ecol  = COL_FW'(ec);
    r.src   = s;
    r.last  = 1'b0;
    return r;
  endfunction

  assign off_inc  = (&off_r)  ? off_r  : off_r  + 1'b1;
  assign line_inc = (&line_r) ? line_r : line_r + 1'b1;
  assign col_inc  = (&col_r)  ? col_r  : col_r  + 1'b1;

  assign pending = (mode_r == MODE_DEC) || (mode_r == MODE_ZERO) || (mode_r == MODE_HEX) ||
                   (mode_r == MODE_IDENT);

  assign extend = ((mode_r == MODE_DEC)   && is_digit(symbol)) ||
                  ((mode_r == MODE_HEX)   && is_xdigit(symbol)) ||
                  ((mode_r == MODE_IDENT) && is_word(symbol)) ||
                  ((mode_r == MODE_ZERO)  && (is_digit(symbol) || (symbol == CH_X_LO) ||
                                              (symbol == CH_X_UP)));

  assign tok = mk_res((mode_r == MODE_IDENT) ? KIND_IDENT : KIND_INT, tstart_off_r, off_r,
                      line_r, tstart_col_r, line_r, col_r, tag);

  always_comb begin
    mode_nxt       = mode_r;
    off_nxt        = off_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    tstart_off_nxt = tstart_off_r;
    tstart_col_nxt = tstart_col_r;
    flush          = 1'b0;
    sec_v          = 1'b0;
    sec            = mk_res(KIND_DONE, off_r, off_r, line_r, col_r, line_r, col_r, tag);
    if (acc) begin
      if (opcode) begin
        flush          = pending;
        sec_v          = 1'b1;
        mode_nxt       = MODE_IDLE;
        off_nxt        = '0;
        line_nxt       = '0;
        col_nxt        = '0;
        tstart_off_nxt = '0;
        tstart_col_nxt = '0;
      end else if (mode_r == MODE_ERROR) begin
        mode_nxt = MODE_ERROR;
      end else if (extend) begin
        off_nxt = off_inc;
        col_nxt = col_inc;
        if (mode_r == MODE_ZERO) begin
          mode_nxt = is_digit(symbol) ? MODE_DEC : MODE_HEX;
        end
      end else begin
        flush    = pending;
        mode_nxt = MODE_IDLE;
        priority if (symbol == CH_NL) begin
          sec_v    = 1'b1;
          sec      = mk_res(KIND_NEWLINE, off_r, off_inc, line_r, col_r, line_inc, '0, tag);
          off_nxt  = off_inc;
          line_nxt = line_inc;
          col_nxt  = '0;
        end else if (is_space(symbol)) begin
          off_nxt = off_inc;
          col_nxt = col_inc;
        end else if (is_punct(symbol)) begin
          sec_v   = 1'b1;
          sec     = mk_res(punct_kind(symbol), off_r, off_inc, line_r, col_r, line_r, col_inc,
                           tag);
          off_nxt = off_inc;
          col_nxt = col_inc;
        end else if (is_word(symbol)) begin
          priority if (!is_digit(symbol)) begin
            mode_nxt = MODE_IDENT;
          end else if (symbol == CH_ZERO) begin
            mode_nxt = MODE_ZERO;
          end else begin
            mode_nxt = MODE_DEC;
          end
          tstart_off_nxt = off_r;
          tstart_col_nxt = col_r;
          off_nxt        = off_inc;
          col_nxt        = col_inc;
        end else begin
          sec_v    = 1'b1;
          sec      = mk_res(KIND_ERROR, off_r, off_inc, line_r, col_r, line_r, col_inc, tag);
          mode_nxt = MODE_ERROR;
        end
      end
    end
  end

  always_comb begin
    push.r0 = tok;
    push.r1 = sec;
    push.n  = 2'd0;
    if (flush) begin
      push.n       = sec_v ? 2'd2 : 2'd1;
      push.r0.last = !sec_v;
      push.r1.last = 1'b1;
    end else if (sec_v) begin
      push.n       = 2'd1;
      push.r0      = sec;
      push.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      off_r        <= '0;
      line_r       <= '0;
      col_r        <= '0;
      tstart_off_r <= '0;
      tstart_col_r <= '0;
    end else begin
      mode_r       <= mode_nxt;
      off_r        <= off_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      tstart_off_r <= tstart_off_nxt;
      tstart_col_r <= tstart_col_nxt;
    end
  end

endmodule

/* design/alx_outq.sv */
// Four-entry result queue taking up to two results per cycle and giving one while out_ready is high.
// Depends on alx_pkg for the result and push types.
module alx_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  alx_pkg::alx_push_t  push,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output alx_pkg::alx_res_t   out_res
);
  import alx_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  alx_res_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic [PW-1:0]   wr_ptr_p1;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign space     = (count_r <= CW'(QDEPTH - 2));
  assign wr_ptr_p1 = PW'(wr_ptr_r + 1'b1);

  always_comb begin
    wr_ptr_nxt = PW'(wr_ptr_r + push.n);
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = CW'(count_r + push.n - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/assembly_lexer.sv */
// Top level of the assembly source lexer: source tag register, lexer core, result queue.
// Depends on alx_pkg, alx_core and alx_outq.
//
// The lexer takes one text byte or end-of-text item per cycle while in_tready is high and
// emits tokens with their begin and end spans. An item is lexed in the cycle it is accepted;
// its results are written into a four-entry result queue and appear at the output from the
// next cycle on, one per cycle unless stalled. in_tready is high while the queue has at
// least two free entries, so with out_tready held high the block sustains one item per
// cycle; the queue absorbs both results of an item that flushes a token and emits another.
// out_tlast marks the last result caused by an item. The source tag is written through the
// cfg channel, which is always ready, and should be changed only while the block is idle.
module assembly_lexer #(
  parameter int OFFSET_WIDTH = alx_pkg::OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = alx_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = alx_pkg::COLUMN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // symbol
  input  logic [0:0]                    in_tuser,  // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // start offset, stop offset, start line, start column, stop line, stop column, source tag
  output logic [alx_pkg::DATA_W-1:0]    out_tdata,
  output logic [alx_pkg::KIND_FW-1:0]   out_tuser, // kind
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [alx_pkg::TAG_FW-1:0]    cfg_data
);
  import alx_pkg::*;

  logic [TAG_FW-1:0] tag_r, tag_nxt;
  logic              in_acc;
  logic              space;
  alx_push_t         push;
  alx_res_t          res;

  assign cfg_ready = 1'b1;
  assign tag_nxt   = (cfg_valid && cfg_ready) ? cfg_data : tag_r;
  assign in_tready = space;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  alx_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .opcode (in_tuser[0]),
    .symbol (in_tdata),
    .tag    (tag_r),
    .push   (push)
  );

  alx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.src, res.ecol, res.eline, res.bcol, res.bline, res.eoff, res.boff};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

`ifndef SYNTHESIS
  a_eot_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> out_tvalid)
    else $error("end-of-text item left no result");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_DONE)) |-> out_tlast)
    else $error("done result not marked last");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= KIND_DONE))
    else $error("result kind out of range");

  a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_NEWLINE)) |->
      (out_tdata[ECOL_LSB +: COL_FW] == '0))
    else $error("newline token end column not zero");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for assembly_lexer: streams source bytes and end-of-text items, predicts
// every token span as items are accepted and compares results field by field. Needs alx_pkg.
module tb;
  import alx_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int F_EOFF      = OFS_FW;
  localparam int F_BLINE     = 2 * OFS_FW;
  localparam int F_BCOL      = F_BLINE + LINE_FW;
  localparam int F_ELINE     = F_BCOL + COL_FW;
  localparam int F_ECOL      = F_ELINE + LINE_FW;
  localparam int F_SRC       = F_ECOL + COL_FW;

  typedef struct packed {
    logic       eot;
    logic [7:0] sym;
  } text_item_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic [0:0]          in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic [KIND_FW-1:0]  out_tuser;
  logic                out_tlast;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [TAG_FW-1:0]   cfg_data   = '0;

  text_item_t text_q[$];
  alx_res_t   expected_tokens[$];
  alx_res_t   step_tokens[$];
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         mismatches    = 0;
  int         quiet         = 0;

  alx_mode_t          scan_m   = MODE_IDLE;
  logic [OFS_FW-1:0]  ofs_m    = '0;
  logic [OFS_FW-1:0]  tokofs_m = '0;
  logic [LINE_FW-1:0] line_m   = '0;
  logic [COL_FW-1:0]  col_m    = '0;
  logic [COL_FW-1:0]  tokcol_m = '0;
  logic [TAG_FW-1:0]  tag_m    = '0;

  assembly_lexer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial forever #2 clk = ~clk;

  function automatic logic [OFS_FW-1:0] ofs_inc(input logic [OFS_FW-1:0] v);
    return &v ? v : v + 1'b1;
  endfunction

  function automatic logic [COL_FW-1:0] col_inc(input logic [COL_FW-1:0] v);
    return &v ? v : v + 1'b1;
  endfunction

  task automatic emit_span(input alx_kind_t k, input logic [OFS_FW-1:0] bo,
                           input logic [OFS_FW-1:0] eo, input logic [LINE_FW-1:0] bl,
                           input logic [COL_FW-1:0] bc, input logic [LINE_FW-1:0] el,
                           input logic [COL_FW-1:0] ec);
    alx_res_t r;
    r.kind  = k;
    r.boff  = bo;
    r.eoff  = eo;
    r.bline = bl;
    r.bcol  = bc;
    r.eline = el;
    r.ecol  = ec;
    r.src   = tag_m;
    r.last  = 1'b0;
    step_tokens.insert(step_tokens.size(), r);
  endtask

  task automatic flush_token();
    if (scan_m inside {MODE_DEC, MODE_ZERO, MODE_HEX, MODE_IDENT}) begin
      emit_span(scan_m == MODE_IDENT ? KIND_IDENT : KIND_INT, tokofs_m, ofs_m, line_m,
                tokcol_m, line_m, col_m);
      scan_m = MODE_IDLE;
    end
  endtask

  task automatic step_pos();
    ofs_m = ofs_inc(ofs_m);
    col_m = col_inc(col_m);
  endtask

  task automatic lex_predict(input logic eot, input logic [7:0] c);
    logic               digit, word, xdig;
    alx_kind_t          k;
    logic [OFS_FW-1:0]  b0;
    logic [COL_FW-1:0]  c0;
    logic [LINE_FW-1:0] nl;
    step_tokens.delete();
    digit = c inside {[8'h30:8'h39]};
    word  = digit || c == CH_UNDER || c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    xdig  = digit || c inside {[8'h41:8'h46], [8'h61:8'h66]};
    if (eot) begin
      flush_token();
      emit_span(KIND_DONE, ofs_m, ofs_m, line_m, col_m, line_m, col_m);
      scan_m   = MODE_IDLE;
      ofs_m    = '0;
      line_m   = '0;
      col_m    = '0;
      tokofs_m = '0;
      tokcol_m = '0;
    end else if (scan_m == MODE_ERROR) begin
    end else if ((scan_m == MODE_DEC && digit) || (scan_m == MODE_HEX && xdig) ||
                 (scan_m == MODE_IDENT && word)) begin
      step_pos();
    end else if (scan_m == MODE_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
      scan_m = MODE_HEX;
      step_pos();
    end else if (scan_m == MODE_ZERO && digit) begin
      scan_m = MODE_DEC;
      step_pos();
    end else begin
      flush_token();
      case (c)
        CH_NL: begin
          nl = &line_m ? line_m : line_m + 1'b1;
          emit_span(KIND_NEWLINE, ofs_m, ofs_inc(ofs_m), line_m, col_m, nl, '0);
          ofs_m  = ofs_inc(ofs_m);
          line_m = nl;
          col_m  = '0;
        end
        CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF: step_pos();
        CH_COMMA, CH_PLUS, CH_MINUS, CH_LBR, CH_RBR: begin
          k = c == CH_COMMA ? KIND_COMMA : c == CH_PLUS ? KIND_PLUS :
              c == CH_MINUS ? KIND_MINUS : c == CH_LBR ? KIND_LBR : KIND_RBR;
          b0 = ofs_m;
          c0 = col_m;
          step_pos();
          emit_span(k, b0, ofs_m, line_m, c0, line_m, col_m);
        end
        default: begin
          if (word) begin
            scan_m   = !digit ? MODE_IDENT : (c == CH_ZERO ? MODE_ZERO : MODE_DEC);
            tokofs_m = ofs_m;
            tokcol_m = col_m;
            step_pos();
          end else begin
            emit_span(KIND_ERROR, ofs_m, ofs_inc(ofs_m), line_m, col_m, line_m, col_inc(col_m));
            scan_m = MODE_ERROR;
          end
        end
      endcase
    end
    if (step_tokens.size() != 0) step_tokens[$].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endtask

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    if (mismatches < 40) $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // hold the item until accepted, then advance the queue
  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    logic       go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) lex_predict(in_tuser[0], in_tdata);
      go = text_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (go) begin
        nxt = text_q.pop_front();
        in_tdata <= nxt.sym;
        in_tuser <= nxt.eot;
      end
      in_tvalid <= go;
    end
  end

  always @(posedge clk) begin
    out_tready <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin : check_tokens
    alx_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind  = alx_kind_t'(out_tuser);
      got.boff  = out_tdata[0 +: OFS_FW];
      got.eoff  = out_tdata[F_EOFF +: OFS_FW];
      got.bline = out_tdata[F_BLINE +: LINE_FW];
      got.bcol  = out_tdata[F_BCOL +: COL_FW];
      got.eline = out_tdata[F_ELINE +: LINE_FW];
      got.ecol  = out_tdata[F_ECOL +: COL_FW];
      got.src   = out_tdata[F_SRC +: TAG_FW];
      got.last  = out_tlast;
      if (expected_tokens.size() == 0) begin
        report("unexpected token of kind", got.kind, 0);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind) report("kind", got.kind, want.kind);
        if (got.boff !== want.boff) report("begin_offset", got.boff, want.boff);
        if (got.eoff !== want.eoff) report("end_offset", got.eoff, want.eoff);
        if (got.bline !== want.bline) report("start_line", got.bline, want.bline);
        if (got.bcol !== want.bcol) report("start_col", got.bcol, want.bcol);
        if (got.eline !== want.eline) report("stop_line", got.eline, want.eline);
        if (got.ecol !== want.ecol) report("stop_col", got.ecol, want.ecol);
        if (got.src !== want.src) report("span_source", got.src, want.src);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** assembly_lexer: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic starts_nothing(input logic [7:0] c);
    return !(c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER, CH_NL, CH_SPACE,
                       CH_TAB, CH_CR, CH_VT, CH_FF, CH_COMMA, CH_PLUS, CH_MINUS, CH_LBR,
                       CH_RBR});
  endfunction

  function automatic logic [7:0] rand_letter();
    int i;
    i = $urandom_range(52);
    if (i < 26) return 8'(8'h61 + i);
    if (i < 52) return 8'(8'h41 + i - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_word();
    int i;
    i = $urandom_range(62);
    if (i < 10) return 8'(CH_ZERO + i);
    if (i < 36) return 8'(8'h61 + i - 10);
    if (i < 62) return 8'(8'h41 + i - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_xdigit();
    int i;
    i = $urandom_range(21);
    if (i < 10) return 8'(CH_ZERO + i);
    if (i < 16) return 8'(8'h61 + i - 10);
    return 8'(8'h41 + i - 16);
  endfunction

  task automatic push_byte(input logic [7:0] c);
    text_item_t t;
    t.eot = 1'b0;
    t.sym = c;
    text_q.insert(text_q.size(), t);
  endtask

  task automatic push_eot();
    text_item_t t;
    t.eot = 1'b1;
    t.sym = 8'($urandom);
    text_q.insert(text_q.size(), t);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  task automatic push_stream(output int counted);
    int         n_lex, len, pick;
    logic [7:0] c;
    counted = 0;
    n_lex = $urandom_range(1, 14);
    for (int l = 0; l < n_lex; l++) begin
      pick = $urandom_range(99);
      len  = $urandom_range(5);
      if (pick < 24) begin
        push_byte(rand_letter());
        repeat (len) push_byte(rand_word());
        counted += len + 1;
      end else if (pick < 34) begin
        push_byte($urandom_range(1) ? CH_ZERO : 8'(CH_ZERO + $urandom_range(1, 9)));
        repeat (len) push_byte(8'(CH_ZERO + $urandom_range(9)));
        counted += len + 1;
      end else if (pick < 44) begin
        push_byte(CH_ZERO);
        push_byte($urandom_range(1) ? CH_X_LO : CH_X_UP);
        len = $urandom_range(4);
        repeat (len) push_byte(rand_xdigit());
        counted += len + 2;
      end else if (pick < 64) begin
        case ($urandom_range(4))
          0: c = CH_COMMA;
          1: c = CH_PLUS;
          2: c = CH_MINUS;
          3: c = CH_LBR;
          default: c = CH_RBR;
        endcase
        push_byte(c);
        counted++;
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0: c = CH_SPACE;
          1: c = CH_TAB;
          2: c = CH_CR;
          3: c = CH_VT;
          default: c = CH_FF;
        endcase
        push_byte(c);
        counted++;
      end else if (pick < 90) begin
        push_byte(CH_NL);
        counted++;
      end else if (pick < 94) begin
        push_byte(8'($urandom));
        counted++;
      end else begin
        do c = 8'($urandom); while (!starts_nothing(c));
        push_byte(c);
        counted++;
        repeat ($urandom_range(3)) push_byte(8'($urandom));
        break;
      end
    end
    push_eot();
    counted++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (text_q.size() != 0 || in_tvalid || expected_tokens.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tag(input logic [TAG_FW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tag_m = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int budget);
    int sent, n;
    sent = 0;
    while (sent < budget) begin
      push_stream(n);
      sent += n;
    end
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_text("_Az9\t0x,07+0XfF-[ ]\n");
    push_byte(CH_CR);
    push_byte(CH_VT);
    push_byte(CH_FF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_text("b");
    push_eot();
    push_text("0x");
    push_eot();
    push_eot();
    wait_drained();

    write_tag(16'hFFFF);
    run_random(425);

    write_tag(16'($urandom));
    send_idle_pct = 57;
    run_random(425);

    write_tag(16'($urandom));
    send_idle_pct = 0;
    stall_pct     = 57;
    // drain everything with an identifier still pending
    push_text("mov r1");
    wait_drained();
    push_text("2, [r3+0x1f]\n");
    push_eot();
    run_random(425);

    write_tag(16'h0000);
    send_idle_pct = 34;
    stall_pct     = 34;
    run_random(425);

    write_tag(16'($urandom));
    send_idle_pct = 0;
    stall_pct     = 0;
    push_text("a1,");
    push_byte(8'h7F);
    push_eot();
    wait_drained();

    if (mismatches == 0) begin
      $display("** assembly_lexer: PASSED **");
    end else begin
      $display("** assembly_lexer: FAILED **");
    end
    $finish;
  end

endmodule
